>>> rtl/core/rbsr_pkg.sv
// ----------------------------------------------------------------------------
// rbsr_pkg
// Shared constants, types and BCD helpers for the serial time readout.
// ----------------------------------------------------------------------------
package rbsr_pkg;

  localparam int unsigned WORD_BITS = 40;

  localparam logic [2:0] CMD_SHIFT     = 3'd1;
  localparam logic [2:0] CMD_TIME_READ = 3'd3;

  localparam int unsigned BIT_CLOCK  = 1;
  localparam int unsigned BIT_STROBE = 2;
  localparam int unsigned CMD_LSB    = 3;
  localparam int unsigned CMD_MSB    = 5;

  typedef struct packed {
    logic load;
    logic shift;
  } rbsr_ctl_t;

  // split a value below 64 into tens and ones nibbles
  function automatic logic [7:0] bcd_split(input logic [5:0] v);
    logic [13:0] p;
    logic [3:0]  tens;
    logic [7:0]  prod;
    logic [5:0]  ones;
    p    = 14'(v) * 14'd205;
    tens = {1'b0, p[13:11]};
    prod = 8'(tens) * 8'd10;
    ones = v - prod[5:0];
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [WORD_BITS-1:0] build_word(
    input logic [5:0] sec,
    input logic [5:0] min,
    input logic [4:0] hr,
    input logic [4:0] dom,
    input logic [2:0] dow,
    input logic [3:0] mon
  );
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] h;
    logic [7:0] d;
    s = bcd_split(sec);
    m = bcd_split(min);
    h = bcd_split({1'b0, hr});
    d = bcd_split({1'b0, dom});
    return {mon, {1'b0, dow}, d, h, m, s};
  endfunction

endpackage

>>> rtl/core/rbsr_cell.sv
// ----------------------------------------------------------------------------
// rbsr_cell
// Time chain bit: load, load and shift, shift from the upper neighbour, hold.
// ----------------------------------------------------------------------------
module rbsr_cell
  import rbsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rbsr_ctl_t ctl_i,
  input  logic      load_bit_i,
  input  logic      load_next_i,
  input  logic      shift_in_i,
  output logic      bit_o
);

  logic bit_q;
  logic bit_d;

  always_comb begin
    bit_d = bit_q;
    if (ctl_i.load && ctl_i.shift) begin
      bit_d = load_next_i;
    end else if (ctl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctl_i.shift) begin
      bit_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

>>> rtl/core/rbsr_ctrl.sv
// ----------------------------------------------------------------------------
// rbsr_ctrl
// Control byte decoding: strobe and clock edge detection, command latch.
// ----------------------------------------------------------------------------
module rbsr_ctrl
  import rbsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       mode_i,
  input  logic [7:0] write_data_i,
  output rbsr_ctl_t  ctl_o
);

  logic       strobe_q, strobe_d;
  logic       clock_q, clock_d;
  logic [2:0] cmd_q, cmd_d;
  logic       write;
  logic       strobe_rise;
  logic       clock_rise;

  always_comb begin
    write       = accept_i && mode_i;
    strobe_rise = write_data_i[BIT_STROBE] && !strobe_q;
    clock_rise  = write_data_i[BIT_CLOCK] && !clock_q;
    strobe_d    = strobe_q;
    clock_d     = clock_q;
    cmd_d       = cmd_q;
    if (write) begin
      strobe_d = write_data_i[BIT_STROBE];
      clock_d  = write_data_i[BIT_CLOCK];
      if (strobe_rise) begin
        cmd_d = write_data_i[CMD_MSB:CMD_LSB];
      end
    end
    ctl_o.load  = write && strobe_rise && (cmd_d == CMD_TIME_READ);
    ctl_o.shift = write && clock_rise && ((cmd_d == CMD_SHIFT) || (cmd_d == CMD_TIME_READ));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      clock_q  <= 1'b0;
      cmd_q    <= 3'd0;
    end else begin
      strobe_q <= strobe_d;
      clock_q  <= clock_d;
      cmd_q    <= cmd_d;
    end
  end

endmodule

>>> rtl/core/rtc_bcd_serial_readout.sv
// ----------------------------------------------------------------------------
// rtc_bcd_serial_readout
// Bus-side serial clock chip: BCD time word shifted out one bit per clock.
// ----------------------------------------------------------------------------
// Each input transfer is one bus access: a read of the data register
// (mode 0) or a write of the control byte (mode 1). A rising strobe latches
// the command; the time-read command loads the 40-bit BCD time word from
// the time fields into a row of one-bit cells. A rising clock under the
// shift or time-read command moves the row down one cell, zeros entering
// at the top, so the word runs out to 0 after its last bit.
// Every input transfer gives one output transfer whose read_data carries
// the bottom cell in bit 7; bits 6..0 are 0.
// The result is registered and valid in the cycle after the input transfer.
// A new access is taken every cycle while in_stall_o is low; the rate is
// set by the single output register. While the receiver stalls, the pending
// result holds and in_stall_o is raised, so at most one result is ever held.
// Reset clears the edge detectors, the command, the cells and the output.
// ----------------------------------------------------------------------------
module rtc_bcd_serial_readout
  import rbsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] write_data_i,
  input  logic [5:0] second_i,
  input  logic [5:0] minute_i,
  input  logic [4:0] hour_i,
  input  logic [4:0] day_of_month_i,
  input  logic [2:0] day_of_week_i,
  input  logic [3:0] month_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  logic                 accept;
  rbsr_ctl_t            ctl;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS:0]   word_ext;
  logic [WORD_BITS:0]   chain;
  logic                 next_bit;
  logic                 out_valid_q, out_valid_d;
  logic                 out_bit_q, out_bit_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign word     = build_word(second_i, minute_i, hour_i, day_of_month_i,
                               day_of_week_i, month_i);
  assign word_ext = {1'b0, word};
  assign chain[WORD_BITS] = 1'b0;

  rbsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .write_data_i (write_data_i),
    .ctl_o        (ctl)
  );

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    rbsr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .load_bit_i  (word_ext[i]),
      .load_next_i (word_ext[i+1]),
      .shift_in_i  (chain[i+1]),
      .bit_o       (chain[i])
    );
  end

  always_comb begin
    if (ctl.load && ctl.shift) begin
      next_bit = word_ext[1];
    end else if (ctl.load) begin
      next_bit = word_ext[0];
    end else if (ctl.shift) begin
      next_bit = chain[1];
    end else begin
      next_bit = chain[0];
    end
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_bit_d   = next_bit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_bit_q   <= out_bit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = {out_bit_q, 7'd0};

endmodule

>>> rtl/core/rbsr_checker.sv
// ----------------------------------------------------------------------------
// rbsr_checker
// Port-level checks for the serial time readout, bound to the top level.
// ----------------------------------------------------------------------------
module rbsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       mode_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);

  a_low_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o[6:0] == 7'd0))
    else $error("read_data low bits not zero");

  a_transfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("input transfer without result");

  a_read_keeps_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !mode_i && out_valid_o && !out_stall_i)
      |=> (read_data_o == $past(read_data_o)))
    else $error("read access changed data register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)))
    else $error("stalled result changed");

endmodule

bind rtc_bcd_serial_readout rbsr_checker u_rbsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial clock chip BCD time readout.
// ----------------------------------------------------------------------------
// A short table of bus accesses covers reset, the command latch, strobe and
// clock rising together, ignored commands, spare control bits and time
// values beyond their range. A random part follows: mostly complete time
// readouts, some running past the last bit, mixed with reads, command
// changes and noise. Results are checked against table values or a local
// chip model, while the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rbsr_pkg::*;

  localparam logic       MODE_READ   = 1'b0;
  localparam logic       MODE_WRITE  = 1'b1;
  localparam logic [2:0] CMD_HOLD    = 3'd0;
  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam logic [7:0] DATA_SET    = 8'h80;
  localparam logic [7:0] DATA_CLEAR  = 8'h00;
  localparam logic [7:0] SPARE_BITS  = 8'hC1;
  localparam int         RANDOM_ITEMS = 900;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_ALTERNATE,
    STALL_RANDOM,
    STALL_BURSTS
  } stall_style_e;

  typedef struct {
    logic       mode;
    logic [7:0] ctl;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] mday;
    logic [2:0] wday;
    logic [3:0] months;
    bit         known;
    logic [7:0] value;
  } access_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic       mode_i         = MODE_READ;
  logic [7:0] write_data_i   = '0;
  logic [5:0] second_i       = '0;
  logic [5:0] minute_i       = '0;
  logic [4:0] hour_i         = '0;
  logic [4:0] day_of_month_i = '0;
  logic [2:0] day_of_week_i  = '0;
  logic [3:0] month_i        = '0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] read_data_o;

  // checker side of the current transfer
  bit         row_known = 1'b0;
  logic [7:0] row_value = '0;

  // model state
  logic        strobe_q = 1'b0;
  logic        clock_q  = 1'b0;
  logic [2:0]  cmd_q    = CMD_HOLD;
  logic        bit_q    = 1'b0;
  logic [39:0] word_q   = '0;
  int unsigned pos_q    = 0;

  logic [7:0]   expected_data[$];
  access_t      directed[$];
  int           mismatches      = 0;
  int           results_checked = 0;
  int           accesses_sent   = 0;
  int           time_loads      = 0;
  int           shift_clocks    = 0;
  int           word_overruns   = 0;
  int           burst_left      = 0;
  bit           idle_on         = 1'b1;
  logic [15:0]  stall_tick      = '0;
  stall_style_e stall_style     = STALL_NONE;

  rtc_bcd_serial_readout DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .write_data_i   (write_data_i),
    .second_i       (second_i),
    .minute_i       (minute_i),
    .hour_i         (hour_i),
    .day_of_month_i (day_of_month_i),
    .day_of_week_i  (day_of_week_i),
    .month_i        (month_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [39:0] time_word(input int s, input int m, input int h,
                                            input int d, input int w, input int mo);
    return {4'(mo), 4'(w), 4'(d / 10), 4'(d % 10), 4'(h / 10), 4'(h % 10),
            4'(m / 10), 4'(m % 10), 4'(s / 10), 4'(s % 10)};
  endfunction

  function automatic logic [7:0] ctl_byte(input logic [2:0] cmd, input logic strobe,
                                          input logic clock);
    logic [7:0] b;
    b = '0;
    b[CMD_MSB:CMD_LSB] = cmd;
    b[BIT_STROBE] = strobe;
    b[BIT_CLOCK] = clock;
    return b;
  endfunction

  // advance the model by one bus access, return the data register
  function automatic logic [7:0] readout_step(input logic mode, input logic [7:0] ctl,
                                              input logic [5:0] s, input logic [5:0] m,
                                              input logic [4:0] h, input logic [4:0] d,
                                              input logic [2:0] w, input logic [3:0] mo);
    logic strobe;
    logic clock;
    strobe = ctl[BIT_STROBE];
    clock = ctl[BIT_CLOCK];
    if (mode == MODE_WRITE) begin
      if (strobe && !strobe_q) begin
        cmd_q = ctl[CMD_MSB:CMD_LSB];
        if (cmd_q == CMD_TIME_READ) begin
          word_q = time_word(s, m, h, d, w, mo);
          pos_q = 0;
          bit_q = word_q[0];
          time_loads++;
        end
      end
      if (clock && !clock_q && (cmd_q == CMD_SHIFT || cmd_q == CMD_TIME_READ)) begin
        shift_clocks++;
        if (pos_q < WORD_BITS) begin
          pos_q++;
        end else begin
          word_overruns++;
        end
        bit_q = (pos_q < WORD_BITS) ? word_q[pos_q] : 1'b0;
      end
      strobe_q = strobe;
      clock_q = clock;
    end
    return bit_q ? DATA_SET : DATA_CLEAR;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
  endtask

  task automatic send(input access_t a);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (idle_on) begin
        repeat ($urandom_range(1, 5)) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= a.mode;
    write_data_i   <= a.ctl;
    second_i       <= a.seconds;
    minute_i       <= a.minutes;
    hour_i         <= a.hours;
    day_of_month_i <= a.mday;
    day_of_week_i  <= a.wday;
    month_i        <= a.months;
    row_known      <= a.known;
    row_value      <= a.value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    accesses_sent++;
  endtask

  // random time fields, mostly in range, sometimes anywhere in the field
  task automatic send_random(input logic mode, input logic [7:0] ctl);
    access_t a;
    bit      in_range;
    in_range  = $urandom_range(0, 3) != 0;
    a.mode    = mode;
    a.ctl     = ctl;
    a.seconds = in_range ? 6'($urandom_range(0, 59)) : 6'($urandom_range(0, 63));
    a.minutes = in_range ? 6'($urandom_range(0, 59)) : 6'($urandom_range(0, 63));
    a.hours   = in_range ? 5'($urandom_range(0, 23)) : 5'($urandom_range(0, 31));
    a.mday    = in_range ? 5'($urandom_range(1, 31)) : 5'($urandom_range(0, 31));
    a.wday    = in_range ? 3'($urandom_range(0, 6)) : 3'($urandom_range(0, 7));
    a.months  = in_range ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
    a.known   = 1'b0;
    a.value   = '0;
    send(a);
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 3) == 0) begin
      send_random(MODE_READ, 8'($urandom));
    end
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[7:0] == 8'd0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
    end
    case (stall_style)
      STALL_NONE:      out_stall_i <= 1'b0;
      STALL_ALTERNATE: out_stall_i <= stall_tick[0];
      STALL_RANDOM:    out_stall_i <= ($urandom_range(0, 2) == 0);
      default:         out_stall_i <= (stall_tick[3:0] < 4'd6);
    endcase
  end

  // check results, then predict for the transfer taken at this edge
  always @(posedge clk_i) begin : check_results
    logic [7:0] want;
    logic [7:0] predicted;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_data.size() == 0) begin
          report_mismatch("unexpected result", read_data_o, DATA_CLEAR);
        end else begin
          want = expected_data.pop_front();
          results_checked++;
          if (read_data_o !== want) begin
            report_mismatch("read_data", read_data_o, want);
          end
        end
      end
      if (in_valid_i && in_stall_o === 1'b0) begin
        predicted = readout_step(mode_i, write_data_i, second_i, minute_i, hour_i,
                                 day_of_month_i, day_of_week_i, month_i);
        expected_data.push_back(row_known ? row_value : predicted);
      end
    end
  end

  initial begin
    int         n;
    int         kind;
    logic [2:0] cmd_run;

    // mode, control, sec, min, hour, mday, wday, month, known, value
    directed.push_back('{MODE_READ, 8'h00, 0, 0, 0, 0, 0, 0, 1, DATA_CLEAR});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_SHIFT, 1, 0), 0, 0, 0, 1, 0, 1,
                         1, DATA_CLEAR});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_SHIFT, 1, 1), 0, 0, 0, 1, 0, 1,
                         1, DATA_CLEAR});
    directed.push_back('{MODE_WRITE, 8'h00, 0, 0, 0, 1, 0, 1, 1, DATA_CLEAR});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 1, 0), 59, 59, 23, 31, 6, 12,
                         1, DATA_SET});
    directed.push_back('{MODE_READ, 8'hFF, 63, 63, 31, 31, 7, 15, 1, DATA_SET});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 0, 1), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 0, 0), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 0, 1), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_UNUSED, 1, 0), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_UNUSED, 0, 1), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, 8'hFF, 63, 63, 31, 31, 7, 15, 0, 0});
    directed.push_back('{MODE_WRITE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 1, 1) | SPARE_BITS,
                         63, 63, 31, 31, 7, 15, 0, 0});
    directed.push_back('{MODE_WRITE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 1, 0), 0, 0, 0, 1, 0, 1,
                         1, DATA_CLEAR});
    directed.push_back('{MODE_WRITE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_TIME_READ, 1, 0), 37, 48, 19, 26, 3, 9,
                         0, 0});
    directed.push_back('{MODE_WRITE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_SHIFT, 1, 0), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_SHIFT, 1, 1), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_READ, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_HOLD, 1, 0), 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MODE_WRITE, ctl_byte(CMD_HOLD, 0, 1), 0, 0, 0, 0, 0, 0, 0, 0});

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send(directed[i]);
    end

    while (accesses_sent < directed.size() + RANDOM_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // complete time readout, sometimes past the last bit
        cmd_run = CMD_TIME_READ;
        send_random(MODE_WRITE, (8'($urandom) & SPARE_BITS) | ctl_byte(cmd_run, 0, 0));
        send_random(MODE_WRITE, (8'($urandom) & SPARE_BITS) |
                    ctl_byte(cmd_run, 1, $urandom_range(0, 4) == 0));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(38, 46) : $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          if (i == n / 2 && $urandom_range(0, 4) == 0) begin
            cmd_run = CMD_SHIFT;
            send_random(MODE_WRITE, ctl_byte(cmd_run, 1, 0));
          end
          send_random(MODE_WRITE, (8'($urandom) & SPARE_BITS) | ctl_byte(cmd_run, 0, 1));
          maybe_read();
          send_random(MODE_WRITE, (8'($urandom) & SPARE_BITS) | ctl_byte(cmd_run, 0, 0));
          maybe_read();
        end
      end else if (kind <= 7) begin
        repeat ($urandom_range(5, 20)) begin
          send_random(1'($urandom), 8'($urandom));
        end
      end else begin
        // broken sequences: random commands with stray strobes
        send_random(MODE_WRITE, ctl_byte(3'($urandom), 1, 1'($urandom)));
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
          send_random(MODE_WRITE, ctl_byte(3'($urandom), $urandom_range(0, 5) == 0,
                                           1'(i)));
          maybe_read();
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_data.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results from %0d bus accesses.", results_checked, accesses_sent);
    $display("Time loads %0d, shift clocks %0d, clocks past the last bit %0d.",
             time_loads, shift_clocks, word_overruns);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rbsr_pkg.sv
rtl/core/rbsr_cell.sv
rtl/core/rbsr_ctrl.sv
rtl/core/rtc_bcd_serial_readout.sv
rtl/core/rbsr_checker.sv
bench/tb.sv
